// ----- design/mac_duplicate_frame_filter_macros.svh -----
// assertion helpers, sampled on clk and quiet while arst_n is low
`ifndef MAC_DUPLICATE_FRAME_FILTER_MACROS_SVH
`define MAC_DUPLICATE_FRAME_FILTER_MACROS_SVH

// same-cycle implication
`define MDFF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdff assertion failed");

// next-cycle implication
`define MDFF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdff assertion failed");

`endif

// ----- design/mdff_pkg.sv -----
package mdff_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int ADDR_BITS  = 64;
	localparam int TIME_BITS  = 32;
	localparam int SEQ_W      = 8;
	localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int AGE_W      = (TIME_BITS > 32) ? TIME_BITS : 32;

	// fixed port widths
	localparam int IN_ADDR_W   = 64;
	localparam int IN_TIME_W   = 32;
	localparam int MAX_AGE_W   = 32;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 8;

	localparam logic [MAX_AGE_W-1:0] MAX_AGE_RST = 32'd2560;

	typedef enum logic {
		REQ_CHECK    = 1'b0,
		REQ_REGISTER = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] sender;
		logic [SEQ_W-1:0]     seq;
		logic [TIME_BITS-1:0] stamp;
	} ent_t;

	typedef struct packed {
		req_kind_t kind;
		ent_t      ent;
	} req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic dup;
	} eng_stat_t;

endpackage

// ----- design/mdff_ram.sv -----
module mdff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/mdff_engine.sv -----
`include "mac_duplicate_frame_filter_macros.svh"

module mdff_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  mdff_pkg::req_t                   req,
	input  logic [mdff_pkg::MAX_AGE_W-1:0]   max_age,
	input  logic                             out_free,
	output mdff_pkg::eng_stat_t              stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_HEAD,
		ST_DONE
	} state_t;

	localparam logic [mdff_pkg::IDX_W-1:0] LAST_IDX =
		mdff_pkg::IDX_W'(mdff_pkg::HIST_DEPTH - 1);

	state_t                          state_q;
	mdff_pkg::req_t                  req_q;
	logic [mdff_pkg::IDX_W-1:0]      idx_q;
	logic                            issue_q;
	logic                            dup_q;
	logic [mdff_pkg::HIST_DEPTH-1:0] valid_q;

	logic                            rd_vld_s1;
	logic                            rd_shift_s1;
	logic [mdff_pkg::IDX_W-1:0]      rd_idx_s1;
	logic                            ent_vld_s1;

	logic                            rd_en;
	logic                            wr_en;
	logic [mdff_pkg::IDX_W-1:0]      wr_addr;
	mdff_pkg::ent_t                  wr_data;
	logic [$bits(mdff_pkg::ent_t)-1:0] rd_data;
	mdff_pkg::ent_t                  ent;
	logic                            hit;
	logic [mdff_pkg::TIME_BITS-1:0]  age;
	logic                            fresh;
	logic                            scan_look;
	logic                            scan_last;
	logic                            shift_wr;
	logic [mdff_pkg::IDX_W-1:0]      hit_idx;

	// one request per cycle while scanning or moving entries back
	assign rd_en = issue_q && (state_q == ST_SCAN || state_q == ST_SHIFT);

	// entries never written read as the cleared value
	assign ent = ent_vld_s1 ? mdff_pkg::ent_t'(rd_data) : '0;

	assign hit       = (ent.sender == req_q.ent.sender);
	assign age       = req_q.ent.stamp - ent.stamp;
	assign fresh     = (max_age == '0) ||
		(mdff_pkg::AGE_W'(age) <= mdff_pkg::AGE_W'(max_age));
	assign scan_look = (state_q == ST_SCAN) && rd_vld_s1 && !rd_shift_s1;
	assign scan_last = (rd_idx_s1 == LAST_IDX);
	assign shift_wr  = (state_q == ST_SHIFT) && rd_vld_s1 && rd_shift_s1;
	assign hit_idx   = hit ? rd_idx_s1 : LAST_IDX;

	assign wr_en   = shift_wr || (state_q == ST_HEAD);
	assign wr_addr = (state_q == ST_HEAD) ? '0 : rd_idx_s1 + mdff_pkg::IDX_W'(1);
	assign wr_data = (state_q == ST_HEAD) ? req_q.ent : ent;

	mdff_ram #(
		.WIDTH ($bits(mdff_pkg::ent_t)),
		.DEPTH (mdff_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_shift_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			ent_vld_s1  <= 1'b0;
			valid_q     <= '0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_shift_s1 <= (state_q == ST_SHIFT);
			rd_idx_s1   <= idx_q;
			ent_vld_s1  <= valid_q[idx_q];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= '0;
			idx_q   <= '0;
			issue_q <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						idx_q   <= '0;
						issue_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + mdff_pkg::IDX_W'(1);
						end
					end
					// first matching sender ends the scan
					if (scan_look && (hit || scan_last)) begin
						if (req_q.kind == mdff_pkg::REQ_CHECK) begin
							dup_q   <= hit && (ent.seq == req_q.ent.seq) && fresh;
							issue_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (hit_idx == '0) begin
							issue_q <= 1'b0;
							state_q <= ST_HEAD;
						end else begin
							idx_q   <= hit_idx - mdff_pkg::IDX_W'(1);
							issue_q <= 1'b1;
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (issue_q) begin
						if (idx_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q - mdff_pkg::IDX_W'(1);
						end
					end
					if (shift_wr && rd_idx_s1 == '0) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					dup_q   <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE) && out_free;
	assign stat.dup  = dup_q;

	`MDFF_ASSERT_NOW(a_no_rw_clash, rd_en && wr_en, idx_q != wr_addr)
	`MDFF_ASSERT_NOW(a_shift_not_head, shift_wr, wr_addr != '0)
	`MDFF_ASSERT_NOW(a_register_no_dup, stat.done && req_q.kind == mdff_pkg::REQ_REGISTER,
		!stat.dup)
	`MDFF_ASSERT_NEXT(a_head_valid, state_q == ST_HEAD, valid_q[0])

endmodule

// ----- design/mac_duplicate_frame_filter.sv -----
// check request: the result follows the one-entry-per-cycle scan of the
// history memory (first matching sender)
// register request: the scan, then one entry moved back per cycle
// through the memory's read and write ports
// one request in flight; the next is taken the cycle after the result registers
// arst_n clears the history to zeros (per-entry valid bits) and max_age to 2560
module mac_duplicate_frame_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sender_addr, seq_num, now_ticks
	input  logic [mdff_pkg::IN_TDATA_W-1:0]     s_tdata,
	// req_type
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// is_duplicate, zero fill
	output logic [mdff_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mdff_pkg::MAX_AGE_W-1:0]      cfg_data
);

	logic [mdff_pkg::MAX_AGE_W-1:0] max_age_q;
	logic                           m_tvalid_q;
	logic                           out_dup_q;
	logic                           out_free;
	logic                           start;
	mdff_pkg::req_t                 req;
	mdff_pkg::eng_stat_t            stat;

	logic [mdff_pkg::IN_ADDR_W-1:0] in_addr;
	logic [mdff_pkg::SEQ_W-1:0]     in_seq;
	logic [mdff_pkg::IN_TIME_W-1:0] in_now;

	assign in_addr = s_tdata[mdff_pkg::IN_ADDR_W-1:0];
	assign in_seq  = s_tdata[mdff_pkg::IN_ADDR_W +: mdff_pkg::SEQ_W];
	assign in_now  = s_tdata[mdff_pkg::IN_ADDR_W + mdff_pkg::SEQ_W +: mdff_pkg::IN_TIME_W];

	assign req.kind       = mdff_pkg::req_kind_t'(s_tuser);
	assign req.ent.sender = mdff_pkg::ADDR_BITS'(in_addr);
	assign req.ent.seq    = in_seq;
	assign req.ent.stamp  = mdff_pkg::TIME_BITS'(in_now);

	assign s_tready  = !stat.busy;
	assign start     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	mdff_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.max_age  (max_age_q),
		.out_free (out_free),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q  <= mdff_pkg::MAX_AGE_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_age_q <= cfg_data;
			end
			if (stat.done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_dup_q <= stat.dup;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(mdff_pkg::OUT_TDATA_W - 1){1'b0}}, out_dup_q};

endmodule
